@@ src/u8u16_pkg.sv @@
// Shared types and constants of the UTF-8 to UTF-16BE converter.
package u8u16_pkg;

    localparam logic [15:0] BYTE_ORDER_MARK = 16'hFEFF;
    localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;
    localparam logic [20:0] SUPP_BASE       = 21'h010000;
    localparam logic [5:0]  CONT_MASK       = 6'h3F;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Results of one input byte: up to three code units, high first.
    // When err is set, the last of them is the error result and holds zero.
    typedef struct packed {
        logic [1:0]       cnt;
        logic             err;
        logic [2:0][15:0] unit;
    } u8u16_job_t;

endpackage

@@ src/u8u16_byte_if.sv @@
// Byte channel carrying the UTF-8 input stream.
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

@@ src/u8u16_unit_if.sv @@
// Code unit channel carrying the UTF-16BE output stream.
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        coding_error;
    logic        last_of_run;

    modport source (output valid, output code_unit, output coding_error,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_unit, input coding_error,
                    input last_of_run, output ready);
endinterface

@@ src/u8u16_front.sv @@
// Front end: decodes UTF-8 bytes and queues the code units each byte yields.
module u8u16_front (
    input  logic                  clk,
    input  logic                  rst_n,
    u8u16_byte_if.sink            octets,
    input  logic                  full,
    output logic                  push,
    output u8u16_pkg::u8u16_job_t push_job
);
    import u8u16_pkg::*;

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] partial_reg, partial_next;
    logic        mark_sent_reg, mark_sent_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [7:0]  b;
    logic        eos;
    logic [1:0]  pend_dec;
    logic [1:0]  dec_pending;
    logic [20:0] dec_point;
    logic [20:0] shifted;
    logic [20:0] offset;
    logic        done;
    logic        fault;
    logic [1:0]  k;
    u8u16_job_t  job;

    assign b            = octets.data_byte;
    assign eos          = octets.end_of_stream;
    assign octets.ready = !full;
    assign accept       = octets.valid && octets.ready;

    always_comb
    begin
        dec_pending = pending_reg;
        dec_point   = partial_reg;
        done        = 1'b0;
        fault       = 1'b0;
        shifted     = '0;
        pend_dec    = pending_reg - 2'd1;
        if (pending_reg == 2'd0)
        begin
            priority if (!b[7])
            begin
                dec_point = {13'd0, b};
                done      = 1'b1;
            end
            else if (!b[5])
            begin
                dec_point   = {10'd0, b[4:0], 6'd0};
                dec_pending = 2'd1;
            end
            else if (!b[4])
            begin
                dec_point   = {5'd0, b[3:0], 12'd0};
                dec_pending = 2'd2;
            end
            else if (!b[3])
            begin
                dec_point   = {b[2:0], 18'd0};
                dec_pending = 2'd3;
            end
            else
            begin
                fault = 1'b1;
            end
        end
        else
        begin
            dec_pending = pend_dec;
            unique case (pend_dec)
                2'd0:    shifted = {15'd0, b[5:0] & CONT_MASK};
                2'd1:    shifted = {9'd0, b[5:0] & CONT_MASK, 6'd0};
                2'd2:    shifted = {3'd0, b[5:0] & CONT_MASK, 12'd0};
                default: shifted = {b[2:0], 18'd0};
            endcase
            dec_point = partial_reg | shifted;
            done      = (pend_dec == 2'd0);
        end

        // A stream that ends inside a sequence is truncated.
        if (eos && dec_pending != 2'd0 && !fault)
        begin
            fault = 1'b1;
        end

        offset = dec_point - SUPP_BASE;

        // Lay out the results in stream order: mark, units, error.
        k        = 2'd0;
        job.unit = '0;
        if (!mark_sent_reg)
        begin
            job.unit[k] = BYTE_ORDER_MARK;
            k           = k + 2'd1;
        end
        if (done)
        begin
            if (dec_point[20:16] != 5'd0)
            begin
                job.unit[k]        = {HIGH_SURR_TAG, offset[19:10]};
                job.unit[k + 2'd1] = {LOW_SURR_TAG, offset[9:0]};
                k                  = k + 2'd2;
            end
            else
            begin
                job.unit[k] = dec_point[15:0];
                k           = k + 2'd1;
            end
        end
        if (fault)
        begin
            job.unit[k] = 16'd0;
            k           = k + 2'd1;
        end
        job.cnt = k;
        job.err = fault;

        pending_next   = pending_reg;
        partial_next   = partial_reg;
        mark_sent_next = mark_sent_reg;
        halted_next    = halted_reg;
        if (accept && !halted_reg)
        begin
            mark_sent_next = 1'b1;
            pending_next   = fault ? 2'd0 : dec_pending;
            partial_next   = (fault || done) ? 21'd0 : dec_point;
            halted_next    = fault;
        end
    end

    assign push     = accept && !halted_reg && (job.cnt != 2'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            partial_reg   <= 21'd0;
            mark_sent_reg <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            partial_reg   <= partial_next;
            mark_sent_reg <= mark_sent_next;
            halted_reg    <= halted_next;
        end
    end

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("converter left the halted state without reset");

    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (pending_reg == 2'd0 && partial_reg == 21'd0))
        else $error("halted converter keeps a partial sequence");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

endmodule

@@ src/u8u16_queue.sv @@
// Small register queue of decoded jobs between the front and back ends.
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8u16_pkg::u8u16_job_t push_job,
    output logic                  full,
    input  logic                  pop,
    output u8u16_pkg::u8u16_job_t head_job,
    output logic                  empty
);
    import u8u16_pkg::*;

    // DEPTH must be 2 or more.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_job_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/u8u16_back.sv @@
// Back end: plays out the code units of each queued job, one beat per cycle while the units channel is ready.
module u8u16_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  u8u16_pkg::u8u16_job_t head_job,
    output logic                  pop,
    u8u16_unit_if.source          units
);
    import u8u16_pkg::*;

    u8u16_job_t job_reg, job_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       last;
    logic       taken;

    assign last  = (idx_reg == job_reg.cnt - 2'd1);
    assign taken = units.valid && units.ready;
    assign pop   = !empty && (!busy_reg || (taken && last));

    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            job_next  = head_job;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (taken)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        units.valid        = busy_reg;
        units.coding_error = job_reg.err && last;
        units.last_of_run  = last;
        unique case (idx_reg)
            2'd0:    units.code_unit = job_reg.unit[0];
            2'd1:    units.code_unit = job_reg.unit[1];
            2'd2:    units.code_unit = job_reg.unit[2];
            default: units.code_unit = 16'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (job_reg.cnt != 2'd0 && idx_reg < job_reg.cnt))
        else $error("result index beyond the job");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !units.ready) |=> (busy_reg && $stable(idx_reg)))
        else $error("stalled result advanced");

endmodule

@@ src/utf8_to_utf16be_converter_core.sv @@
// Top level of the UTF-8 to UTF-16BE converter.
//
// The converter takes one UTF-8 byte per beat on the octets channel and gives
// UTF-16 code units, big-endian unit order, one per beat on the units channel.
// The very first result after reset is the byte-order mark 0xFEFF. A completed
// sequence gives one code unit, or a surrogate pair (high unit first) for code
// points of 0x10000 and above; last_of_run marks the final result caused by a
// given input byte, and a byte that only extends a sequence gives no result.
// Lead bytes are classified by bits 7, 5, 4 and 3; continuation bytes are not
// checked and only their low six bits are used. A lead byte of 0xF8 or above,
// or end_of_stream on a byte that leaves a sequence open, gives one result with
// coding_error set and code_unit zero, after which every byte is accepted and
// dropped until reset. Rate: the front end accepts a byte in every cycle in
// which its job queue (QUEUE_DEPTH entries, two by default) has room, and the
// back end sends one code unit per cycle from its output register while the
// units channel is ready, so the sustained rate is one byte per cycle for
// single-unit characters; otherwise it is set by the output port, one unit per beat.
// Each result is held in a queue entry and then in the back end's job register.
// Output stalls hold the current beat and back up into the queue, then the input.
module utf8_to_utf16be_converter_core #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    octets,
    u8u16_unit_if.source  units
);
    import u8u16_pkg::*;

    // Decoded jobs pass through the queue so that decoding never waits on
    // the output side beyond the queue's depth.
    logic       push;
    logic       full;
    logic       pop;
    logic       empty;
    u8u16_job_t push_job;
    u8u16_job_t head_job;

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .octets   (octets),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    // The back end steps through the units of one job, one beat per cycle while the
    // units channel is ready, and loads the next queued job in the same cycle the last beat is taken.
    u8u16_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_job (head_job),
        .pop      (pop),
        .units    (units)
    );

endmodule
